### design/assert_macros.svh
// Assertion helpers; bodies drop out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NTCP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define NTCP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NTCP_ASSERT(lbl, clk, rstn, prop, msg)
`define NTCP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### design/ntcp_pkg.sv
package ntcp_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_GGA  = 2'd1;
    localparam logic [1:0] KIND_ZDA  = 2'd2;
    localparam logic [1:0] KIND_VTG  = 2'd3;

    localparam logic [4:0] FIELD_MAX = 5'd31;

    // reciprocals: x/5 = (x*RECIP5)>>18, x/10 = (x*RECIP10)>>19, exact for 16-bit x
    localparam logic [15:0] RECIP5  = 16'd52429;
    localparam logic [15:0] RECIP10 = 16'd52429;

    localparam logic [0:0] REG_TIME_FROM_ZDA = 1'b0;
    localparam logic [0:0] REG_IGNORE_FIX    = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE,
        S_FIN,
        S_G_RD, S_G_CHK, S_G_END,
        S_F_RD, S_F_CHK,
        S_T_START, S_T_DOT_RD, S_T_DOT_CHK, S_T_SCALE, S_T_DIV5, S_T_SUB,
        S_T_HMS0, S_T_H, S_T_M, S_T_S,
        S_DEC_RD, S_DEC_ACC,
        S_C_DOT_RD, S_C_DOT_CHK, S_C_WS0, S_C_WS_RD, S_C_WS_CHK,
        S_C_DIG_RD, S_C_DIG_CHK, S_C_END, S_C_FRAC, S_C_FDIV, S_C_COMB, S_C_STORE,
        S_CR_RD0, S_CR_CHK0, S_CR_RD1, S_CR_CHK1, S_K1, S_K2, S_CR_OUT
    } t_state;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h41 + 8'(v) - 8'd10);
    endfunction

    // sentence tag characters; sel 0 GPGGA, 1 GPZDA, 2 GPVTG
    function automatic logic [7:0] tag_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (pos)
            3'd0: c = 8'h47;
            3'd1: c = 8'h50;
            3'd2: c = (sel == 2'd0) ? 8'h47 : (sel == 2'd1) ? 8'h5A : 8'h56;
            3'd3: c = (sel == 2'd0) ? 8'h47 : (sel == 2'd1) ? 8'h44 : 8'h54;
            3'd4: c = (sel == 2'd0) ? 8'h41 : (sel == 2'd1) ? 8'h41 : 8'h47;
            default: c = 8'h00;
        endcase
        tag_char = c;
    endfunction

endpackage

### design/ntcp_ram.sv
module ntcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/nmea_time_course_parser_top.sv
// Ordinary bytes, '$', '*', LF: taken in the idle state, result offered on the next cycle.
// A comma goes through S_FIN; one that ends a parsed field first runs the sequencer over the
// field buffer, with read and check states per character per pass (two passes for a course).
// CR: the checksum reads two buffered bytes if present, then up to three passes of the multiplier.
// Synchronous active-low reset clears parser state and ignore-fix, sets time-from-ZDA; RAM kept.
`include "assert_macros.svh"

module nmea_time_course_parser_top #(
    parameter int TICKS_PER_SECOND = 7200,
    parameter int BUFFER_DEPTH     = 64,
    parameter int MAX_FIELDS       = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_report_kind,
    output logic signed [31:0] o_time_ticks,
    output logic [15:0]        o_course_hundredths,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] CC_LAST = AW'(BUFFER_DEPTH - 1);
    localparam logic [5:0]  MF6  = 6'(MAX_FIELDS);
    localparam logic [15:0] T1   = 16'(TICKS_PER_SECOND);
    localparam logic [15:0] T10  = 16'(TICKS_PER_SECOND / 10);
    localparam logic [15:0] T100 = 16'(TICKS_PER_SECOND / 100);
    localparam logic [15:0] T200 = 16'(TICKS_PER_SECOND / 200);

    ntcp_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [4:0]    r_fn, n_fn;
    logic [AW-1:0] r_cc, n_cc, r_idx, n_idx, r_dot, n_dot;
    logic [1:0]    r_kind, n_kind, r_rk, n_rk, r_cnt, n_cnt, r_n, n_n;
    logic          r_ck, n_ck, r_fix, n_fix, r_time, n_time, r_cok, n_cok;
    logic [7:0]    r_xor, n_xor, r_h, n_h, r_m, n_m, r_s, n_s;
    logic [15:0]   r_sub, n_sub, r_crs, n_crs, r_whole, n_whole;
    logic [47:0]   r_acc, n_acc;
    logic [2:0]    r_tm, n_tm;
    logic          r_found, n_found, r_neg, n_neg, r_ok0, n_ok0;
    logic          r_zda, r_ign;
    logic          r_ov, n_ov;
    logic [1:0]    r_okind, n_okind;
    logic [31:0]   r_oticks, n_oticks;
    logic [15:0]   r_ocrs, n_ocrs;

    logic [31:0] mul_a, mul_c;
    logic [15:0] mul_b;
    logic [47:0] mul_p;
    logic        w_we;
    logic [7:0]  w_rdata;
    logic        out_free, in_acc, fld_ok, last, blank, digit;
    logic [15:0] dig16, w16;
    logic [AW-1:0] tn, cn;

    ntcp_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cc),
        .i_wdata (i_rx_byte),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = !((r_state == ntcp_pkg::S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fld_ok     = (r_fn != 5'd0) && (({1'b0, r_fn} + 6'd1) < MF6);
    assign last       = (r_idx == (r_cc - AW'(1)));
    assign blank      = (w_rdata == ntcp_pkg::CH_SPACE) || (w_rdata >= 8'd9 && w_rdata <= 8'd13);
    assign digit      = (w_rdata >= ntcp_pkg::CH_ZERO) && (w_rdata <= ntcp_pkg::CH_NINE);
    assign dig16      = 16'(w_rdata) - 16'(ntcp_pkg::CH_ZERO);
    assign w16        = r_neg ? (16'd0 - r_acc[15:0]) : r_acc[15:0];
    assign tn         = r_cc - AW'(7);
    assign cn         = r_cc - r_dot - AW'(1);
    assign mul_p      = (48'(mul_a) * 48'(mul_b)) + 48'(mul_c);

    assign o_out_valid         = r_ov;
    assign o_report_kind       = r_okind;
    assign o_time_ticks        = signed'(r_oticks);
    assign o_course_hundredths = r_ocrs;
    assign pready              = 1'b1;
    assign prdata = (paddr[2] == ntcp_pkg::REG_IGNORE_FIX) ? {31'd0, r_ign} : {31'd0, r_zda};

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_fn = r_fn; n_cc = r_cc; n_idx = r_idx;
        n_dot = r_dot; n_kind = r_kind; n_rk = r_rk; n_cnt = r_cnt; n_n = r_n;
        n_ck = r_ck; n_fix = r_fix; n_time = r_time; n_cok = r_cok; n_xor = r_xor;
        n_h = r_h; n_m = r_m; n_s = r_s; n_sub = r_sub; n_crs = r_crs; n_whole = r_whole;
        n_acc = r_acc; n_tm = r_tm; n_found = r_found; n_neg = r_neg; n_ok0 = r_ok0;
        n_ov = r_ov; n_okind = r_okind; n_oticks = r_oticks; n_ocrs = r_ocrs;
        mul_a = 32'd0; mul_b = 16'd0; mul_c = 32'd0;
        w_we = 1'b0;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            ntcp_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_rx_byte != ntcp_pkg::CH_CR) begin
                        n_ov = 1'b1; n_okind = ntcp_pkg::KIND_NONE;
                        n_oticks = 32'd0; n_ocrs = 16'd0;
                    end
                    priority if (i_rx_byte == ntcp_pkg::CH_DOLLAR) begin
                        n_fn = 5'd1; n_cc = '0; n_kind = ntcp_pkg::KIND_NONE; n_ck = 1'b0;
                        n_fix = 1'b0; n_time = 1'b0; n_cok = 1'b0; n_xor = 8'd0;
                    end else if (i_rx_byte == ntcp_pkg::CH_STAR) begin
                        n_ck = 1'b1; n_cc = '0;
                    end else if (i_rx_byte == ntcp_pkg::CH_COMMA) begin
                        n_xor = r_xor ^ ntcp_pkg::CH_COMMA;
                        n_state = ntcp_pkg::S_FIN;
                        if (fld_ok) begin
                            priority if (r_fn == 5'd1) begin
                                if (r_cc == AW'(5)) begin
                                    n_idx = '0; n_tm = 3'b111; n_state = ntcp_pkg::S_G_RD;
                                end
                            end else if (r_kind == ntcp_pkg::KIND_GGA) begin
                                if (!r_zda) begin
                                    if (r_fn == 5'd2) begin
                                        n_state = ntcp_pkg::S_T_START;
                                    end else if (r_fn == 5'd7) begin
                                        priority if (r_ign) n_fix = 1'b1;
                                        else if (r_cc == '0) n_fix = 1'b0;
                                        else begin
                                            n_idx = '0; n_state = ntcp_pkg::S_F_RD;
                                        end
                                    end
                                end
                            end else if (r_kind == ntcp_pkg::KIND_ZDA) begin
                                if (r_zda && r_fn == 5'd2) n_state = ntcp_pkg::S_T_START;
                            end else if (r_kind == ntcp_pkg::KIND_VTG) begin
                                if (r_fn == 5'd2) begin
                                    if (r_cc == '0) n_cok = 1'b0;
                                    else begin
                                        n_idx = '0; n_found = 1'b0;
                                        n_state = ntcp_pkg::S_C_DOT_RD;
                                    end
                                end
                            end
                        end
                    end else if (i_rx_byte == ntcp_pkg::CH_CR) begin
                        n_rk = ntcp_pkg::KIND_NONE;
                        if (r_cc >= AW'(2)) begin
                            n_idx = '0; n_state = ntcp_pkg::S_CR_RD0;
                        end else begin
                            n_state = ntcp_pkg::S_CR_OUT;
                        end
                    end else if (i_rx_byte == ntcp_pkg::CH_LF) begin
                        n_state = ntcp_pkg::S_IDLE;
                    end else if (r_fn != 5'd0) begin
                        if (r_cc != CC_LAST) begin
                            w_we = 1'b1;
                            n_cc = r_cc + AW'(1);
                            if (!r_ck) n_xor = r_xor ^ i_rx_byte;
                        end else begin
                            n_fn = 5'd0;
                        end
                    end
                end
            end
            ntcp_pkg::S_FIN: begin
                n_cc = '0;
                if (r_fn != ntcp_pkg::FIELD_MAX) n_fn = r_fn + 5'd1;
                n_state = ntcp_pkg::S_IDLE;
            end
            ntcp_pkg::S_G_RD: n_state = ntcp_pkg::S_G_CHK;
            ntcp_pkg::S_G_CHK: begin
                for (int k = 0; k < 3; k++) begin
                    if (w_rdata != ntcp_pkg::tag_char(2'(k), r_idx[2:0])) n_tm[k] = 1'b0;
                end
                if (r_idx == AW'(4)) n_state = ntcp_pkg::S_G_END;
                else begin
                    n_idx = r_idx + AW'(1); n_state = ntcp_pkg::S_G_RD;
                end
            end
            ntcp_pkg::S_G_END: begin
                priority if (r_tm[0]) n_kind = ntcp_pkg::KIND_GGA;
                else if (r_tm[1]) n_kind = ntcp_pkg::KIND_ZDA;
                else if (r_tm[2]) n_kind = ntcp_pkg::KIND_VTG;
                n_state = ntcp_pkg::S_FIN;
            end
            ntcp_pkg::S_F_RD: n_state = ntcp_pkg::S_F_CHK;
            ntcp_pkg::S_F_CHK: begin
                n_fix = (w_rdata != ntcp_pkg::CH_ZERO);
                n_state = ntcp_pkg::S_FIN;
            end
            ntcp_pkg::S_T_START: begin
                priority if (r_cc < AW'(6)) begin
                    n_time = 1'b0;
                    if (r_kind == ntcp_pkg::KIND_ZDA) n_fix = 1'b0;
                    n_state = ntcp_pkg::S_FIN;
                end else if (r_cc >= AW'(8)) begin
                    n_idx = AW'(6); n_state = ntcp_pkg::S_T_DOT_RD;
                end else begin
                    n_sub = 16'd0; n_state = ntcp_pkg::S_T_HMS0;
                end
            end
            ntcp_pkg::S_T_DOT_RD: n_state = ntcp_pkg::S_T_DOT_CHK;
            ntcp_pkg::S_T_DOT_CHK: begin
                if (w_rdata == ntcp_pkg::CH_DOT) begin
                    if (tn > AW'(3)) begin
                        n_time = 1'b0;
                        if (r_kind == ntcp_pkg::KIND_ZDA) n_fix = 1'b0;
                        n_state = ntcp_pkg::S_FIN;
                    end else begin
                        n_n = tn[1:0]; n_cnt = tn[1:0]; n_idx = AW'(7); n_acc = 48'd0;
                        n_ret = ntcp_pkg::S_T_SCALE; n_state = ntcp_pkg::S_DEC_RD;
                    end
                end else begin
                    n_sub = 16'd0; n_state = ntcp_pkg::S_T_HMS0;
                end
            end
            ntcp_pkg::S_DEC_RD: n_state = ntcp_pkg::S_DEC_ACC;
            ntcp_pkg::S_DEC_ACC: begin
                mul_a = {16'd0, r_acc[15:0]}; mul_b = 16'd10; mul_c = {16'd0, dig16};
                n_acc = {32'd0, mul_p[15:0]};
                n_idx = r_idx + AW'(1);
                n_cnt = r_cnt - 2'd1;
                n_state = (r_cnt == 2'd1) ? r_ret : ntcp_pkg::S_DEC_RD;
            end
            ntcp_pkg::S_T_SCALE: begin
                mul_a = {16'd0, r_acc[15:0]};
                mul_b = (r_n == 2'd1) ? T10 : (r_n == 2'd2) ? T100 : ntcp_pkg::RECIP5;
                n_acc = mul_p;
                n_state = (r_n == 2'd3) ? ntcp_pkg::S_T_DIV5 : ntcp_pkg::S_T_SUB;
            end
            ntcp_pkg::S_T_DIV5: begin
                mul_a = {16'd0, r_acc[33:18]}; mul_b = T200;
                n_acc = mul_p; n_state = ntcp_pkg::S_T_SUB;
            end
            ntcp_pkg::S_T_SUB: begin
                n_sub = r_acc[15:0]; n_state = ntcp_pkg::S_T_HMS0;
            end
            ntcp_pkg::S_T_HMS0: begin
                n_idx = AW'(0); n_cnt = 2'd2; n_acc = 48'd0;
                n_ret = ntcp_pkg::S_T_H; n_state = ntcp_pkg::S_DEC_RD;
            end
            ntcp_pkg::S_T_H: begin
                n_h = r_acc[7:0]; n_idx = AW'(2); n_cnt = 2'd2; n_acc = 48'd0;
                n_ret = ntcp_pkg::S_T_M; n_state = ntcp_pkg::S_DEC_RD;
            end
            ntcp_pkg::S_T_M: begin
                n_m = r_acc[7:0]; n_idx = AW'(4); n_cnt = 2'd2; n_acc = 48'd0;
                n_ret = ntcp_pkg::S_T_S; n_state = ntcp_pkg::S_DEC_RD;
            end
            ntcp_pkg::S_T_S: begin
                n_s = r_acc[7:0]; n_time = 1'b1;
                if (r_kind == ntcp_pkg::KIND_ZDA) n_fix = 1'b1;
                n_state = ntcp_pkg::S_FIN;
            end
            ntcp_pkg::S_C_DOT_RD: n_state = ntcp_pkg::S_C_DOT_CHK;
            ntcp_pkg::S_C_DOT_CHK: begin
                priority if (w_rdata == ntcp_pkg::CH_DOT) begin
                    n_found = 1'b1; n_dot = r_idx; n_state = ntcp_pkg::S_C_WS0;
                end else if (last) begin
                    n_state = ntcp_pkg::S_C_WS0;
                end else begin
                    n_idx = r_idx + AW'(1); n_state = ntcp_pkg::S_C_DOT_RD;
                end
            end
            ntcp_pkg::S_C_WS0: begin
                n_idx = '0; n_neg = 1'b0; n_acc = 48'd0; n_state = ntcp_pkg::S_C_WS_RD;
            end
            ntcp_pkg::S_C_WS_RD: n_state = ntcp_pkg::S_C_WS_CHK;
            ntcp_pkg::S_C_WS_CHK: begin
                priority if (blank) begin
                    if (last) n_state = ntcp_pkg::S_C_END;
                    else begin
                        n_idx = r_idx + AW'(1); n_state = ntcp_pkg::S_C_WS_RD;
                    end
                end else if (w_rdata == ntcp_pkg::CH_PLUS || w_rdata == ntcp_pkg::CH_MINUS) begin
                    n_neg = (w_rdata == ntcp_pkg::CH_MINUS);
                    if (last) n_state = ntcp_pkg::S_C_END;
                    else begin
                        n_idx = r_idx + AW'(1); n_state = ntcp_pkg::S_C_DIG_RD;
                    end
                end else begin
                    n_state = ntcp_pkg::S_C_DIG_RD;
                end
            end
            ntcp_pkg::S_C_DIG_RD: n_state = ntcp_pkg::S_C_DIG_CHK;
            ntcp_pkg::S_C_DIG_CHK: begin
                if (digit) begin
                    mul_a = {16'd0, r_acc[15:0]}; mul_b = 16'd10; mul_c = {16'd0, dig16};
                    n_acc = {32'd0, mul_p[15:0]};
                    if (last) n_state = ntcp_pkg::S_C_END;
                    else begin
                        n_idx = r_idx + AW'(1); n_state = ntcp_pkg::S_C_DIG_RD;
                    end
                end else begin
                    n_state = ntcp_pkg::S_C_END;
                end
            end
            ntcp_pkg::S_C_END: begin
                n_whole = w16;
                if (r_found && r_dot != '0) begin
                    if (cn == '0 || cn > AW'(3)) begin
                        n_cok = 1'b0; n_state = ntcp_pkg::S_FIN;
                    end else begin
                        n_n = cn[1:0]; n_cnt = cn[1:0]; n_idx = r_dot + AW'(1);
                        n_acc = 48'd0; n_ret = ntcp_pkg::S_C_FRAC;
                        n_state = ntcp_pkg::S_DEC_RD;
                    end
                end else begin
                    mul_a = {16'd0, w16}; mul_b = 16'd100;
                    n_acc = mul_p; n_state = ntcp_pkg::S_C_STORE;
                end
            end
            ntcp_pkg::S_C_FRAC: begin
                mul_a = {16'd0, r_acc[15:0]};
                mul_b = (r_n == 2'd3) ? ntcp_pkg::RECIP10 : (r_n == 2'd1) ? 16'd10 : 16'd1;
                n_acc = mul_p;
                n_state = (r_n == 2'd3) ? ntcp_pkg::S_C_FDIV : ntcp_pkg::S_C_COMB;
            end
            ntcp_pkg::S_C_FDIV: begin
                n_acc = {32'd0, r_acc[34:19]}; n_state = ntcp_pkg::S_C_COMB;
            end
            ntcp_pkg::S_C_COMB: begin
                mul_a = {16'd0, r_whole}; mul_b = 16'd100; mul_c = {16'd0, r_acc[15:0]};
                n_acc = mul_p; n_state = ntcp_pkg::S_C_STORE;
            end
            ntcp_pkg::S_C_STORE: begin
                n_crs = r_acc[15:0]; n_cok = 1'b1; n_state = ntcp_pkg::S_FIN;
            end
            ntcp_pkg::S_CR_RD0: n_state = ntcp_pkg::S_CR_CHK0;
            ntcp_pkg::S_CR_CHK0: begin
                n_ok0 = (w_rdata == ntcp_pkg::hex_digit(r_xor[7:4]));
                n_idx = AW'(1); n_state = ntcp_pkg::S_CR_RD1;
            end
            ntcp_pkg::S_CR_RD1: n_state = ntcp_pkg::S_CR_CHK1;
            ntcp_pkg::S_CR_CHK1: begin
                n_state = ntcp_pkg::S_CR_OUT;
                if (r_ok0 && w_rdata == ntcp_pkg::hex_digit(r_xor[3:0])) begin
                    if ((r_kind == ntcp_pkg::KIND_GGA || r_kind == ntcp_pkg::KIND_ZDA)
                        && r_time && r_fix) begin
                        mul_a = {24'd0, r_h}; mul_b = 16'd60; mul_c = {24'd0, r_m};
                        n_acc = mul_p; n_rk = r_kind; n_state = ntcp_pkg::S_K1;
                    end else if (r_kind == ntcp_pkg::KIND_VTG && r_cok) begin
                        n_rk = ntcp_pkg::KIND_VTG;
                    end
                end
            end
            ntcp_pkg::S_K1: begin
                mul_a = r_acc[31:0]; mul_b = 16'd60; mul_c = {24'd0, r_s};
                n_acc = mul_p; n_state = ntcp_pkg::S_K2;
            end
            ntcp_pkg::S_K2: begin
                mul_a = r_acc[31:0]; mul_b = T1; mul_c = {16'd0, r_sub};
                n_acc = mul_p; n_state = ntcp_pkg::S_CR_OUT;
            end
            ntcp_pkg::S_CR_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_okind = r_rk;
                    n_oticks = (r_rk == ntcp_pkg::KIND_GGA || r_rk == ntcp_pkg::KIND_ZDA)
                             ? r_acc[31:0] : 32'd0;
                    n_ocrs = (r_rk == ntcp_pkg::KIND_VTG) ? r_crs : 16'd0;
                    n_fn = 5'd0; n_kind = ntcp_pkg::KIND_NONE;
                    n_fix = 1'b0; n_time = 1'b0; n_cok = 1'b0;
                    n_state = ntcp_pkg::S_IDLE;
                end
            end
            default: n_state = ntcp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntcp_pkg::S_IDLE;
            r_fn <= 5'd0; r_cc <= '0; r_kind <= ntcp_pkg::KIND_NONE; r_ck <= 1'b0;
            r_xor <= 8'd0; r_fix <= 1'b0; r_time <= 1'b0; r_cok <= 1'b0;
            r_h <= 8'd0; r_m <= 8'd0; r_s <= 8'd0; r_sub <= 16'd0; r_crs <= 16'd0;
            r_ov <= 1'b0; r_zda <= 1'b1; r_ign <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fn <= n_fn; r_cc <= n_cc; r_kind <= n_kind; r_ck <= n_ck;
            r_xor <= n_xor; r_fix <= n_fix; r_time <= n_time; r_cok <= n_cok;
            r_h <= n_h; r_m <= n_m; r_s <= n_s; r_sub <= n_sub; r_crs <= n_crs;
            r_ov <= n_ov;
            if (psel && penable && pwrite) begin
                if (paddr[2] == ntcp_pkg::REG_TIME_FROM_ZDA) r_zda <= pwdata[0];
                else r_ign <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret; r_idx <= n_idx; r_dot <= n_dot; r_rk <= n_rk; r_cnt <= n_cnt;
        r_n <= n_n; r_whole <= n_whole; r_acc <= n_acc; r_tm <= n_tm; r_found <= n_found;
        r_neg <= n_neg; r_ok0 <= n_ok0;
        r_okind <= n_okind; r_oticks <= n_oticks; r_ocrs <= n_ocrs;
    end

    `NTCP_ASSERT(a_cr_goes_busy, i_clk, i_rst_n, (in_acc && i_rx_byte == ntcp_pkg::CH_CR) |=> (r_state != ntcp_pkg::S_IDLE), "CR transfer did not start the checksum sequence")
    `NTCP_ASSERT(a_cr_clears, i_clk, i_rst_n, (r_state == ntcp_pkg::S_CR_OUT && out_free) |=> (r_fn == 5'd0 && r_kind == ntcp_pkg::KIND_NONE && !r_time && !r_fix && o_out_valid), "sentence state not cleared after CR result")
    `NTCP_ASSERT(a_comma_xor, i_clk, i_rst_n, (in_acc && i_rx_byte == ntcp_pkg::CH_COMMA) |=> (r_xor == ($past(r_xor) ^ ntcp_pkg::CH_COMMA)), "comma not folded into checksum")

endmodule
